// ===== rtl/gci_pkg.sv =====
// Shared types and constants for the gradient colour interpolation unit.
// Used by the channel interfaces and every module of the block; no dependencies.
package gci_pkg;

    localparam int POS_BITS      = 16;
    localparam int COLOR_BITS    = 8;
    localparam int NUM_CH        = 4;
    localparam int COUNT_BITS    = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 48;

    // Blend numerator c0*(d-k) + c1*k is at most 255*65535, so 24 bits hold it.
    localparam int PROD_BITS = POS_BITS + COLOR_BITS;
    // Divider dividend 2*num + d.
    localparam int REM_BITS  = PROD_BITS + 1;
    localparam int QUOT_BITS = COLOR_BITS;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_FIRST = 3'd1;

    // Channel lanes within a colour word, matching the stop register packing.
    localparam int CH_RED   = 3;
    localparam int CH_GREEN = 2;
    localparam int CH_BLUE  = 1;
    localparam int CH_ALPHA = 0;

    typedef logic [NUM_CH-1:0][COLOR_BITS-1:0] t_rgba;

    typedef struct packed {
        logic [POS_BITS-1:0] pos;
        t_rgba               color;
    } t_stop;

    // One classified item: blend weights, divisor and the two end colours.
    typedef struct packed {
        logic [POS_BITS-1:0] span;
        logic [POS_BITS-1:0] w_lo;
        logic [POS_BITS-1:0] w_hi;
        t_rgba               c_lo;
        t_rgba               c_hi;
        logic                color_valid;
    } t_job;

endpackage

// ===== rtl/gci_if.sv =====
// Valid/ready channel interfaces of the gradient colour interpolation unit.
// Depends on gci_pkg for field widths.
interface gci_pos_if;
    logic                          valid;
    logic                          ready;
    logic [gci_pkg::POS_BITS-1:0]  position;

    modport source (output valid, output position, input ready);
    modport sink (input valid, input position, output ready);
endinterface

interface gci_color_if #(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] alpha;
    logic                    color_valid;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output color_valid, input ready);
    modport sink (input valid, input red, input green, input blue, input alpha,
                  input color_valid, output ready);
endinterface

interface gci_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gci_pkg::CFG_IDX_BITS-1:0]  index;
    logic [gci_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/gci_front.sv =====
// Front end: configuration registers, and classification of each position beat
// into a blend job for the back end. Depends on gci_pkg and gci_if.
module gci_front #(
    parameter int MAX_STOPS = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gci_cfg_if.sink       i_cfg,
    gci_pos_if.sink       i_pos,
    input  logic          i_queue_full,
    output logic          o_push,
    output gci_pkg::t_job o_job
);

    logic [gci_pkg::COUNT_BITS-1:0] r_count;
    gci_pkg::t_stop                 r_stop [MAX_STOPS];

    logic [gci_pkg::COUNT_BITS-1:0] used;
    logic                           found;
    logic                           interp;
    gci_pkg::t_stop                 s_prev;
    gci_pkg::t_stop                 s_lo;
    gci_pkg::t_stop                 s_hi;
    gci_pkg::t_stop                 s_last;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < MAX_STOPS; i++) begin
                r_stop[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            if (i_cfg.index == gci_pkg::REG_STOP_COUNT) begin
                r_count <= i_cfg.data[gci_pkg::COUNT_BITS-1:0];
            end
            for (int i = 0; i < MAX_STOPS; i++) begin
                if (i_cfg.index == gci_pkg::CFG_IDX_BITS'(int'(gci_pkg::REG_STOP_FIRST) + i)) begin
                    r_stop[i] <= gci_pkg::t_stop'(i_cfg.data);
                end
            end
        end
    end

    assign used = (r_count > gci_pkg::COUNT_BITS'(MAX_STOPS))
                ? gci_pkg::COUNT_BITS'(MAX_STOPS) : r_count;

    // The first stop in use at or above the position is the upper stop and the
    // one scanned just before it the lower stop.
    always_comb begin
        found  = 1'b0;
        interp = 1'b0;
        s_prev = r_stop[0];
        s_lo   = r_stop[0];
        s_hi   = r_stop[0];
        s_last = r_stop[0];
        for (int i = 0; i < MAX_STOPS; i++) begin
            if (gci_pkg::COUNT_BITS'(i) < used) begin
                s_last = r_stop[i];
                if (!found && (r_stop[i].pos >= i_pos.position)) begin
                    found  = 1'b1;
                    interp = (i != 0);
                    s_lo   = s_prev;
                    s_hi   = r_stop[i];
                end
            end
            s_prev = r_stop[i];
        end
    end

    // A plain stop colour goes through the same blend with weights one and zero.
    always_comb begin
        o_job.color_valid = (used != '0);
        o_job.span        = gci_pkg::POS_BITS'(1);
        o_job.w_lo        = gci_pkg::POS_BITS'(1);
        o_job.w_hi        = '0;
        o_job.c_lo        = '0;
        o_job.c_hi        = '0;
        priority if (used == '0) begin
            o_job.c_lo = '0;
        end else if (!found) begin
            o_job.c_lo = s_last.color;
            o_job.c_hi = s_last.color;
        end else if (!interp) begin
            o_job.c_lo = s_hi.color;
            o_job.c_hi = s_hi.color;
        end else begin
            o_job.span = s_hi.pos - s_lo.pos;
            o_job.w_lo = s_hi.pos - i_pos.position;
            o_job.w_hi = i_pos.position - s_lo.pos;
            o_job.c_lo = s_lo.color;
            o_job.c_hi = s_hi.color;
        end
    end

    assign i_pos.ready = !i_queue_full;
    assign o_push      = i_pos.valid && !i_queue_full;

endmodule

// ===== rtl/gci_queue.sv =====
// Short job queue between the front end and the blend pipeline.
// Depends on gci_pkg for the job type and queue sizing.
module gci_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gci_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_ready,
    output gci_pkg::t_job o_job
);

    gci_pkg::t_job                      r_mem [gci_pkg::QUEUE_DEPTH];
    logic [gci_pkg::QUEUE_PTR_BITS-1:0] r_wr;
    logic [gci_pkg::QUEUE_PTR_BITS-1:0] r_rd;
    logic [gci_pkg::QUEUE_CNT_BITS-1:0] r_count;
    logic                               pop;

    assign o_full  = (r_count == gci_pkg::QUEUE_CNT_BITS'(gci_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + gci_pkg::QUEUE_CNT_BITS'(i_push)
                     - gci_pkg::QUEUE_CNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= gci_pkg::QUEUE_CNT_BITS'(gci_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");

    a_push_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) && i_push |=> o_valid)
        else $error("pushed job not visible at the head");
`endif

endmodule

// ===== rtl/gci_back.sv =====
// Back end: blend numerator per channel, then a restoring divider pipeline
// that yields one quotient bit per stage. Depends on gci_pkg and gci_if.
module gci_back #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  gci_pkg::t_job i_job,
    output logic          o_ready,
    gci_color_if.source   o_color
);

    localparam int NSTG = gci_pkg::QUOT_BITS + 1;
    localparam int LAST = gci_pkg::QUOT_BITS;

    // Stage 0 forms the dividend, stages 1..LAST each settle one quotient bit.
    logic                             r_vld  [NSTG];
    logic [gci_pkg::POS_BITS-1:0]     r_span [NSTG];
    logic                             r_cv   [NSTG];
    logic [gci_pkg::REM_BITS-1:0]     r_rem  [NSTG][gci_pkg::NUM_CH];
    logic [gci_pkg::QUOT_BITS-1:0]    r_q    [1:LAST][gci_pkg::NUM_CH];
    logic [gci_pkg::REM_BITS-1:0]     n_rem0 [gci_pkg::NUM_CH];
    logic                             en;

    assign en      = !r_vld[LAST] || o_color.ready;
    assign o_ready = en;

    // Dividend is 2*(c0*(d-k) + c1*k) + d and divisor 2*d, which rounds half up.
    always_comb begin
        for (int ch = 0; ch < gci_pkg::NUM_CH; ch++) begin
            n_rem0[ch] = {gci_pkg::PROD_BITS'(i_job.c_lo[ch]) * gci_pkg::PROD_BITS'(i_job.w_lo)
                        + gci_pkg::PROD_BITS'(i_job.c_hi[ch]) * gci_pkg::PROD_BITS'(i_job.w_hi),
                          1'b0}
                       + gci_pkg::REM_BITS'(i_job.span);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_span[0] <= i_job.span;
            r_cv[0]   <= i_job.color_valid;
            for (int ch = 0; ch < gci_pkg::NUM_CH; ch++) begin
                r_rem[0][ch] <= n_rem0[ch];
            end
        end
    end

    for (genvar s = 1; s < NSTG; s++) begin : g_div
        localparam int J = gci_pkg::QUOT_BITS - s;
        logic [gci_pkg::REM_BITS-1:0]  dsh;
        logic [gci_pkg::QUOT_BITS-1:0] q_in [gci_pkg::NUM_CH];

        assign dsh = gci_pkg::REM_BITS'({r_span[s-1], 1'b0}) << J;

        if (s == 1) begin : g_first
            always_comb begin
                for (int ch = 0; ch < gci_pkg::NUM_CH; ch++) begin
                    q_in[ch] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                for (int ch = 0; ch < gci_pkg::NUM_CH; ch++) begin
                    q_in[ch] = r_q[s-1][ch];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_span[s] <= r_span[s-1];
                r_cv[s]   <= r_cv[s-1];
                for (int ch = 0; ch < gci_pkg::NUM_CH; ch++) begin
                    if (r_rem[s-1][ch] >= dsh) begin
                        r_rem[s][ch] <= r_rem[s-1][ch] - dsh;
                        r_q[s][ch]   <= q_in[ch] | (gci_pkg::QUOT_BITS'(1) << J);
                    end else begin
                        r_rem[s][ch] <= r_rem[s-1][ch];
                        r_q[s][ch]   <= q_in[ch];
                    end
                end
            end
        end
    end

    assign o_color.valid       = r_vld[LAST];
    assign o_color.color_valid = r_cv[LAST];
    assign o_color.red         = CHANNEL_BITS'(r_q[LAST][gci_pkg::CH_RED]);
    assign o_color.green       = CHANNEL_BITS'(r_q[LAST][gci_pkg::CH_GREEN]);
    assign o_color.blue        = CHANNEL_BITS'(r_q[LAST][gci_pkg::CH_BLUE]);
    assign o_color.alpha       = CHANNEL_BITS'(r_q[LAST][gci_pkg::CH_ALPHA]);

`ifndef SYNTHESIS
    a_zero_invalid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_color.valid && !o_color.color_valid |->
            (o_color.red == '0) && (o_color.green == '0) &&
            (o_color.blue == '0) && (o_color.alpha == '0))
        else $error("colour not zero without stops");

    a_span_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_span[0] != '0))
        else $error("zero divisor entered the divider");

    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] |->
            (r_rem[LAST][0] < gci_pkg::REM_BITS'({r_span[LAST], 1'b0})) &&
            (r_rem[LAST][1] < gci_pkg::REM_BITS'({r_span[LAST], 1'b0})) &&
            (r_rem[LAST][2] < gci_pkg::REM_BITS'({r_span[LAST], 1'b0})) &&
            (r_rem[LAST][3] < gci_pkg::REM_BITS'({r_span[LAST], 1'b0})))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== rtl/gradient_color_interpolation_unit.sv =====
// Gradient colour interpolation unit: position beat in, RGBA beat out.
// Throughput is one beat per cycle while the output is ready, carried by the divider pipeline
// with one quotient bit a stage; each position passes the queue, the dividend stage and the divider.
// A four-entry job queue lets the front end keep taking positions while the output is held.
// Synchronous active-low reset clears the stop count and all stops to zero and empties the pipe.
// Depends on gci_pkg, gci_if, gci_front, gci_queue and gci_back.
module gradient_color_interpolation_unit #(
    parameter int MAX_STOPS    = 6,
    parameter int CHANNEL_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gci_cfg_if.sink     i_cfg,
    gci_pos_if.sink     i_pos,
    gci_color_if.source o_color
);

    gci_pkg::t_job front_job;
    gci_pkg::t_job head_job;
    logic          push;
    logic          queue_full;
    logic          head_valid;
    logic          back_ready;

    gci_front #(
        .MAX_STOPS (MAX_STOPS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_pos        (i_pos),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (front_job)
    );

    gci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .i_ready (back_ready),
        .o_job   (head_job)
    );

    gci_back #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_job   (head_job),
        .o_ready (back_ready),
        .o_color (o_color)
    );

endmodule
